// ----- rtl/core/uart_command_line_recognizer_top_macros.svh -----
// ----------------------------------------------------------------------------
// UART command line recogniser assertion macros
// Shared concurrent assertion forms, clocked on clk with active-low reset.
// ----------------------------------------------------------------------------
`ifndef UART_COMMAND_LINE_RECOGNIZER_TOP_MACROS_SVH
`define UART_COMMAND_LINE_RECOGNIZER_TOP_MACROS_SVH

// same-cycle implication
`define UCL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define UCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/ucl_pkg.sv -----
// ----------------------------------------------------------------------------
// UART command line recogniser package
// Widths, constants, command codes and the keyword matcher.
// ----------------------------------------------------------------------------
package ucl_pkg;

    localparam int LINE_CAPACITY = 128;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);
    localparam int HEAD_DEPTH    = 7;
    localparam int HEAD_IDX_W    = $clog2(HEAD_DEPTH);
    localparam int MIN_LINE      = 3;
    localparam int NOISE_PERCENT = 25;
    localparam int PERCENT_SCALE = 100;
    localparam int NOISE_W       = LEN_W + 7;
    localparam int AGE_W         = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int COUNT_W       = 32;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic [CFG_W-1:0] CHAR_TIMEOUT_RST     = 16'd2000;
    localparam logic [CFG_W-1:0] CONNECT_WINDOW_RST   = 16'd5000;
    localparam logic [CFG_W-1:0] DISCONNECT_AFTER_RST = 16'd15000;

    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_STOP   = 3'd1,
        CMD_STATUS = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_HELP   = 3'd4,
        CMD_OTHER  = 3'd5
    } cmd_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHAR_TIMEOUT     = 2'd0,
        CFG_CONNECT_WINDOW   = 2'd1,
        CFG_DISCONNECT_AFTER = 2'd2
    } cfg_idx_t;

    typedef logic [HEAD_DEPTH-1:0][7:0] head_t;

    localparam logic [HEAD_DEPTH*8-1:0] WORD_START  = "start";
    localparam logic [HEAD_DEPTH*8-1:0] WORD_STOP   = "stop";
    localparam logic [HEAD_DEPTH*8-1:0] WORD_STATUS = "status";
    localparam logic [HEAD_DEPTH*8-1:0] WORD_ERASE  = "erase";
    localparam logic [HEAD_DEPTH*8-1:0] WORD_HELP   = "help";

    function automatic logic word_eq(input head_t lc, input logic [LEN_W-1:0] tl,
                                     input logic [HEAD_DEPTH*8-1:0] w, input int wl);
        logic eq;
        eq = (tl == LEN_W'(wl));
        for (int i = 0; i < HEAD_DEPTH; i++)
        begin
            if (i < wl && lc[i] != w[(wl-1-i)*8 +: 8])
                eq = 1'b0;
        end
        return eq;
    endfunction

    function automatic cmd_code_t match_cmd(input head_t head, input logic [LEN_W-1:0] tl);
        head_t lc;
        cmd_code_t code;
        for (int i = 0; i < HEAD_DEPTH; i++)
        begin
            lc[i] = (head[i] >= "A" && head[i] <= "Z") ? head[i] + 8'd32 : head[i];
        end
        if (word_eq(lc, tl, WORD_START, 5))
            code = CMD_START;
        else if (word_eq(lc, tl, WORD_STOP, 4))
            code = CMD_STOP;
        else if (word_eq(lc, tl, WORD_STATUS, 6))
            code = CMD_STATUS;
        else if (word_eq(lc, tl, WORD_ERASE, 5))
            code = CMD_ERASE;
        else if (word_eq(lc, tl, WORD_HELP, 4))
            code = CMD_HELP;
        else
            code = CMD_OTHER;
        return code;
    endfunction

endpackage

// ----- rtl/core/ucl_if.sv -----
// ----------------------------------------------------------------------------
// UART command line recogniser channels
// Valid/ready channels for input beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface ucl_in_if
    import ucl_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface ucl_out_if
    import ucl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               command_ready;
    logic [2:0]         command_code;
    logic               connected;
    logic [COUNT_W-1:0] link_total;

    modport source (output valid, output command_ready, output command_code,
                    output connected, output link_total, input ready);
    modport sink   (input valid, input command_ready, input command_code,
                    input connected, input link_total, output ready);
endinterface

interface ucl_cfg_if
    import ucl_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/uart_command_line_recognizer_top.sv -----
// ----------------------------------------------------------------------------
// UART command line recogniser
// Gathers received bytes into a line, flushes on newline or silence, matches
// keywords and tracks link activity from millisecond ticks.
// ----------------------------------------------------------------------------
// An input beat is held in the input register; the line state and result
// register are then updated together when the beat advances.
// Throughput: one beat per cycle; the input register drains whenever the
// result register is empty or being taken.
// Reset: asynchronous, clears line state, ages, link flag, count and
// restores register defaults; head bytes are not cleared.
`include "uart_command_line_recognizer_top_macros.svh"

module uart_command_line_recognizer_top
    import ucl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ucl_in_if.sink    in_ch,
    ucl_out_if.source out_ch,
    ucl_cfg_if.sink   cfg_ch
);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);
    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(MIN_LINE);
    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    logic [CFG_W-1:0] char_timeout_reg;
    logic [CFG_W-1:0] connect_window_reg;
    logic [CFG_W-1:0] disconnect_after_reg;

    logic       in_valid_reg;
    logic       in_mode_reg;
    logic [7:0] in_byte_reg;

    head_t              head_reg;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   ctrl_reg, ctrl_next;
    logic [LEN_W-1:0]   lwc_reg, lwc_next;
    logic [LEN_W-1:0]   lwb_reg, lwb_next;
    logic               zero_seen_reg, zero_seen_next;
    logic [LEN_W-1:0]   zero_pos_reg, zero_pos_next;
    logic [AGE_W-1:0]   idle_reg, idle_next;
    logic [AGE_W-1:0]   age_reg, age_next;
    logic               link_reg, link_next;
    logic [COUNT_W-1:0] conn_cnt_reg, conn_cnt_next;

    logic      out_valid_reg;
    logic      cmd_ready_reg, cmd_ready_next;
    cmd_code_t cmd_code_reg, cmd_code_next;

    logic             advance;
    logic             store;
    logic             is_crlf;
    logic             is_ctrl;
    logic             head_we;
    logic             fire;
    logic             noise;
    logic [LEN_W-1:0] noise_len;
    logic [LEN_W-1:0] match_len;
    logic [LEN_W-1:0] text_len;

    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;
    assign cfg_ch.ready = 1'b1;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.command_ready = cmd_ready_reg;
    assign out_ch.command_code  = cmd_code_reg;
    assign out_ch.connected     = link_reg;
    assign out_ch.link_total    = conn_cnt_reg;

    assign store   = (len_reg < LEN_MAX);
    assign is_crlf = (in_byte_reg == CHAR_CR) || (in_byte_reg == CHAR_LF);
    assign is_ctrl = (in_byte_reg < CHAR_SPACE) && !is_crlf && (in_byte_reg != CHAR_TAB);
    assign head_we = advance && !in_mode_reg && store && (len_reg < LEN_W'(HEAD_DEPTH));

    // floor(ctrl*100/len) > 25  <=>  ctrl*100 >= 26*len
    assign noise_len = in_mode_reg ? len_reg : lwc_reg;
    assign noise = (noise_len < LEN_MIN)
        || (NOISE_W'(ctrl_reg) * NOISE_W'(PERCENT_SCALE)
            >= NOISE_W'(noise_len) * NOISE_W'(NOISE_PERCENT + 1));

    assign match_len = in_mode_reg ? lwb_reg : lwc_reg;
    assign text_len  = (zero_seen_reg && zero_pos_reg < match_len) ? zero_pos_reg : match_len;

    always_comb
    begin
        len_next       = len_reg;
        ctrl_next      = ctrl_reg;
        lwc_next       = lwc_reg;
        lwb_next       = lwb_reg;
        zero_seen_next = zero_seen_reg;
        zero_pos_next  = zero_pos_reg;
        idle_next      = idle_reg;
        age_next       = age_reg;
        link_next      = link_reg;
        conn_cnt_next  = conn_cnt_reg;
        fire           = 1'b0;

        if (!in_mode_reg)
        begin
            if (store)
            begin
                if (is_ctrl)
                    ctrl_next = ctrl_reg + 1'b1;
                if (!is_crlf)
                begin
                    lwc_next = len_reg + 1'b1;
                    if (in_byte_reg != CHAR_SPACE)
                        lwb_next = len_reg + 1'b1;
                end
                if (in_byte_reg == CHAR_NUL && !zero_seen_reg)
                begin
                    zero_seen_next = 1'b1;
                    zero_pos_next  = len_reg;
                end
                len_next = len_reg + 1'b1;
            end
            idle_next = '0;
            age_next  = '0;
            if (in_byte_reg == CHAR_LF)
            begin
                fire           = !noise;
                len_next       = '0;
                ctrl_next      = '0;
                lwc_next       = '0;
                lwb_next       = '0;
                zero_seen_next = 1'b0;
                zero_pos_next  = '0;
            end
        end
        else
        begin
            if (idle_reg != AGE_MAX)
                idle_next = idle_reg + 1'b1;
            if (age_reg != AGE_MAX)
                age_next = age_reg + 1'b1;
            if (len_reg != '0 && idle_next > char_timeout_reg)
            begin
                fire           = !noise && (lwb_reg >= LEN_MIN);
                len_next       = '0;
                ctrl_next      = '0;
                lwc_next       = '0;
                lwb_next       = '0;
                zero_seen_next = 1'b0;
                zero_pos_next  = '0;
            end
            if (age_next < connect_window_reg)
            begin
                if (!link_reg)
                begin
                    link_next     = 1'b1;
                    conn_cnt_next = conn_cnt_reg + 1'b1;
                end
            end
            else if (age_next > disconnect_after_reg)
            begin
                link_next = 1'b0;
            end
        end

        cmd_ready_next = fire && (text_len != '0);
        cmd_code_next  = cmd_ready_next ? match_cmd(head_reg, text_len) : CMD_START;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_timeout_reg     <= CHAR_TIMEOUT_RST;
            connect_window_reg   <= CONNECT_WINDOW_RST;
            disconnect_after_reg <= DISCONNECT_AFTER_RST;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_CHAR_TIMEOUT:     char_timeout_reg     <= cfg_ch.data;
                CFG_CONNECT_WINDOW:   connect_window_reg   <= cfg_ch.data;
                CFG_DISCONNECT_AFTER: disconnect_after_reg <= cfg_ch.data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_mode_reg <= in_ch.mode;
            in_byte_reg <= in_ch.rx_byte;
        end
        if (head_we)
        begin
            head_reg[len_reg[HEAD_IDX_W-1:0]] <= in_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ctrl_reg      <= '0;
            lwc_reg       <= '0;
            lwb_reg       <= '0;
            zero_seen_reg <= 1'b0;
            zero_pos_reg  <= '0;
            idle_reg      <= '0;
            age_reg       <= '0;
            link_reg      <= 1'b0;
            conn_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            cmd_ready_reg <= 1'b0;
            cmd_code_reg  <= CMD_START;
        end
        else
        begin
            if (advance)
            begin
                len_reg       <= len_next;
                ctrl_reg      <= ctrl_next;
                lwc_reg       <= lwc_next;
                lwb_reg       <= lwb_next;
                zero_seen_reg <= zero_seen_next;
                zero_pos_reg  <= zero_pos_next;
                idle_reg      <= idle_next;
                age_reg       <= age_next;
                link_reg      <= link_next;
                conn_cnt_reg  <= conn_cnt_next;
                cmd_ready_reg <= cmd_ready_next;
                cmd_code_reg  <= cmd_code_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `UCL_ASSERT_NOW(a_code_idle, clk, rst_n, out_valid_reg && !cmd_ready_reg, cmd_code_reg == CMD_START)
    `UCL_ASSERT_NEXT(a_byte_clears_idle, clk, rst_n, advance && !in_mode_reg, idle_reg == '0 && age_reg == '0)
    `UCL_ASSERT_NOW(a_count_on_connect, clk, rst_n, conn_cnt_reg != $past(conn_cnt_reg), $rose(link_reg))
    `UCL_ASSERT_NOW(a_ctrl_within_len, clk, rst_n, 1'b1, ctrl_reg <= len_reg && lwb_reg <= lwc_reg)

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// UART command line recogniser testbench
// Drives received bytes and millisecond ticks through the input channel,
// predicts each result beat with a behavioural line tracker or a typed row,
// and checks the result channel beat by beat. A short directed table comes
// first, then random well-formed lines, noise, overflows and tick bursts
// over several register settings and idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top
    import ucl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 200;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int REPORT_MAX    = 10;
    localparam int SETTLE_CYCLES = 8;

    localparam int IDLE_PLAN [PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_NONE, IDLE_RECEIVER,
                                          IDLE_BOTH, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

    typedef struct packed {
        logic               cmd_ready;
        logic [2:0]         cmd_code;
        logic               connected;
        logic [COUNT_W-1:0] conn_count;
    } line_rsp_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic       typed;
        line_rsp_t  rsp;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{MODE_TICK, 8'hA5,      1'b1, '{1'b0, CMD_START, 1'b1, 32'd1}},
        '{MODE_BYTE, "h",        1'b0, '0},
        '{MODE_BYTE, "E",        1'b0, '0},
        '{MODE_BYTE, "l",        1'b0, '0},
        '{MODE_BYTE, "p",        1'b0, '0},
        '{MODE_BYTE, CHAR_LF,    1'b1, '{1'b1, CMD_HELP, 1'b1, 32'd1}},
        '{MODE_BYTE, "S",        1'b0, '0},
        '{MODE_BYTE, "T",        1'b0, '0},
        '{MODE_BYTE, "O",        1'b0, '0},
        '{MODE_BYTE, "P",        1'b0, '0},
        '{MODE_BYTE, CHAR_CR,    1'b0, '0},
        '{MODE_BYTE, CHAR_LF,    1'b0, '0},
        '{MODE_BYTE, CHAR_NUL,   1'b0, '0},
        '{MODE_BYTE, "a",        1'b0, '0},
        '{MODE_BYTE, "b",        1'b0, '0},
        '{MODE_BYTE, CHAR_LF,    1'b1, '{1'b0, CMD_START, 1'b1, 32'd1}},
        '{MODE_BYTE, 8'hFF,      1'b0, '0},
        '{MODE_BYTE, 8'h01,      1'b0, '0},
        '{MODE_BYTE, 8'h02,      1'b0, '0},
        '{MODE_BYTE, CHAR_LF,    1'b1, '{1'b0, CMD_START, 1'b1, 32'd1}},
        '{MODE_BYTE, "x",        1'b0, '0},
        '{MODE_BYTE, CHAR_LF,    1'b0, '0},
        '{MODE_TICK, 8'hFF,      1'b0, '0},
        '{MODE_BYTE, CHAR_LF,    1'b0, '0}
    };

    logic clk;
    logic rst_n;

    ucl_in_if  in_ch ();
    ucl_out_if out_ch ();
    ucl_cfg_if cfg_ch ();

    uart_command_line_recognizer_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // line tracker state
    logic [7:0]         line_head [HEAD_DEPTH];
    int                 line_len;
    int                 line_ctrl;
    int                 len_no_crlf;
    int                 len_no_blank;
    int                 zero_pos;
    bit                 zero_hit;
    logic [AGE_W-1:0]   quiet_ms;
    logic [AGE_W-1:0]   link_age_ms;
    bit                 link_up;
    logic [COUNT_W-1:0] link_count;
    logic [CFG_W-1:0]   timeout_ms;
    logic [CFG_W-1:0]   connect_ms;
    logic [CFG_W-1:0]   drop_ms;

    line_rsp_t line_results [$];
    line_rsp_t seen;
    line_rsp_t want;
    int        mismatches;
    int        beats_sent;
    int        src_idle_pct;
    int        snk_stall_pct;
    int        quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit word_hit(input int tl, input string w);
        logic [7:0] c;
        if (tl != w.len())
            return 1'b0;
        for (int i = 0; i < w.len(); i++)
        begin
            c = line_head[i];
            if (c >= "A" && c <= "Z")
                c = c + 8'd32;
            if (c != w[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit line_noisy(input int len);
        if (len < MIN_LINE)
            return 1'b1;
        return (line_ctrl * PERCENT_SCALE) / len > NOISE_PERCENT;
    endfunction

    task automatic classify(input int len, output bit hit, output cmd_code_t code);
        int tl;
        tl   = (zero_hit && zero_pos < len) ? zero_pos : len;
        hit  = (tl != 0);
        code = CMD_START;
        if (hit)
        begin
            if (word_hit(tl, "start"))
                code = CMD_START;
            else if (word_hit(tl, "stop"))
                code = CMD_STOP;
            else if (word_hit(tl, "status"))
                code = CMD_STATUS;
            else if (word_hit(tl, "erase"))
                code = CMD_ERASE;
            else if (word_hit(tl, "help"))
                code = CMD_HELP;
            else
                code = CMD_OTHER;
        end
    endtask

    task automatic drop_line();
        line_len     = 0;
        line_ctrl    = 0;
        len_no_crlf  = 0;
        len_no_blank = 0;
        zero_pos     = 0;
        zero_hit     = 1'b0;
    endtask

    task automatic recognise(input logic m, input logic [7:0] b, output line_rsp_t r);
        bit        hit;
        cmd_code_t code;
        hit  = 1'b0;
        code = CMD_START;
        if (m == MODE_BYTE)
        begin
            if (line_len < LINE_CAPACITY - 1)
            begin
                if (line_len < HEAD_DEPTH)
                    line_head[line_len] = b;
                if (b < CHAR_SPACE && b != CHAR_CR && b != CHAR_LF && b != CHAR_TAB)
                    line_ctrl++;
                if (b != CHAR_CR && b != CHAR_LF)
                begin
                    len_no_crlf = line_len + 1;
                    if (b != CHAR_SPACE)
                        len_no_blank = line_len + 1;
                end
                if (b == CHAR_NUL && !zero_hit)
                begin
                    zero_hit = 1'b1;
                    zero_pos = line_len;
                end
                line_len++;
            end
            quiet_ms    = '0;
            link_age_ms = '0;
            if (b == CHAR_LF)
            begin
                if (!line_noisy(len_no_crlf))
                    classify(len_no_crlf, hit, code);
                drop_line();
            end
        end
        else
        begin
            if (quiet_ms != '1)
                quiet_ms++;
            if (link_age_ms != '1)
                link_age_ms++;
            if (line_len > 0 && quiet_ms > timeout_ms)
            begin
                if (!line_noisy(line_len) && len_no_blank >= MIN_LINE)
                    classify(len_no_blank, hit, code);
                drop_line();
            end
            if (link_age_ms < connect_ms)
            begin
                if (!link_up)
                begin
                    link_up = 1'b1;
                    link_count++;
                end
            end
            else if (link_age_ms > drop_ms)
                link_up = 1'b0;
        end
        r.cmd_ready  = hit;
        r.cmd_code   = hit ? code : CMD_START;
        r.connected  = link_up;
        r.conn_count = link_count;
    endtask

    task automatic send_item(input logic m, input logic [7:0] b,
                             input bit typed = 1'b0, input line_rsp_t typed_rsp = '0);
        line_rsp_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= m;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        recognise(m, b, r);
        line_results.push_back(typed ? typed_rsp : r);
        beats_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_item(MODE_TICK, 8'($urandom_range(255)));
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (line_results.size() != 0)
            @(posedge clk);
    endtask

    // leaves valid high; caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            CFG_CHAR_TIMEOUT:     timeout_ms = val;
            CFG_CONNECT_WINDOW:   connect_ms = val;
            CFG_DISCONNECT_AFTER: drop_ms    = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [CFG_W-1:0] ct, input logic [CFG_W-1:0] cw,
                             input logic [CFG_W-1:0] da);
        write_reg(CFG_CHAR_TIMEOUT, ct);
        write_reg(CFG_CONNECT_WINDOW, cw);
        write_reg(CFG_DISCONNECT_AFTER, da);
    endtask

    task automatic send_sequence();
        logic [7:0] text [$];
        string      w;
        logic [7:0] c;
        int         kind;
        int         n;
        bit         by_ticks;
        kind     = $urandom_range(99);
        by_ticks = 1'b0;
        if (kind < 60)
        begin
            case ($urandom_range(6))
                0: w = "start";
                1: w = "stop";
                2: w = "status";
                3: w = "erase";
                4: w = "help";
                5: w = "helps";
                default: w = "";
            endcase
            for (int i = 0; i < w.len(); i++)
            begin
                c = w[i];
                if ($urandom_range(1))
                    c = c - 8'd32;
                text.push_back(c);
            end
            if (w.len() == 0)
                repeat ($urandom_range(1, 9))
                    text.push_back(8'($urandom_range(8'h21, 8'h7E)));
            if ($urandom_range(99) < 15)
            begin
                text.push_back(CHAR_NUL);
                repeat ($urandom_range(1, 3))
                    text.push_back(8'($urandom_range(255)));
            end
            repeat ($urandom_range(2))
                text.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_CR);
            if (timeout_ms <= 100 && $urandom_range(1))
                by_ticks = 1'b1;
            else
                text.push_back(CHAR_LF);
        end
        else if (kind < 75)
            send_ticks($urandom_range(1, 90));
        else if (kind < 90)
        begin
            repeat ($urandom_range(1, 12))
                text.push_back(8'($urandom_range(255)));
            if ($urandom_range(1))
                text.push_back(CHAR_LF);
        end
        else if (kind < 98)
        begin
            repeat ($urandom_range(3, 10))
            begin
                if ($urandom_range(99) < 30)
                    text.push_back($urandom_range(3) == 0 ? CHAR_TAB
                                                          : 8'($urandom_range(1, 31)));
                else
                    text.push_back(8'($urandom_range(8'h21, 8'h7E)));
            end
            text.push_back(CHAR_LF);
        end
        else
        begin
            // lines around the line capacity, most of them past it
            n = $urandom_range(125, 135);
            if ($urandom_range(1))
            begin
                text.push_back("h");
                text.push_back("E");
                text.push_back("l");
                text.push_back("P");
                text.push_back(CHAR_NUL);
            end
            while (text.size() < n)
                text.push_back(8'($urandom_range(8'h21, 8'h7E)));
            text.push_back(CHAR_LF);
        end
        foreach (text[k])
        begin
            if ($urandom_range(9) == 0)
                send_ticks($urandom_range(1, 3));
            send_item(MODE_BYTE, text[k]);
        end
        if (by_ticks)
            send_ticks(int'(timeout_ms) + $urandom_range(1, 3));
    endtask

    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen.cmd_ready  = out_ch.command_ready;
            seen.cmd_code   = out_ch.command_code;
            seen.connected  = out_ch.connected;
            seen.conn_count = out_ch.link_total;
            if (line_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected beat: ready=%0d code=%0d conn=%0d count=%0d",
                             seen.cmd_ready, seen.cmd_code, seen.connected,
                             seen.conn_count);
            end
            else
            begin
                want = line_results.pop_front();
                if (seen.cmd_ready !== want.cmd_ready || seen.cmd_code !== want.cmd_code ||
                    seen.connected !== want.connected || seen.conn_count !== want.conn_count)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("beat mismatch: exp ready=%0d code=%0d conn=%0d count=%0d,",
                                 want.cmd_ready, want.cmd_code, want.connected,
                                 want.conn_count,
                                 " got ready=%0d code=%0d conn=%0d count=%0d",
                                 seen.cmd_ready, seen.cmd_code, seen.connected,
                                 seen.conn_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("uart_command_line_recognizer_top: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_BYTE;
        in_ch.rx_byte = 8'h00;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_CHAR_TIMEOUT;
        cfg_ch.data   = '0;
        out_ch.ready  = 1'b0;
        mismatches    = 0;
        beats_sent    = 0;
        quiet_cycles  = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        timeout_ms    = CHAR_TIMEOUT_RST;
        connect_ms    = CONNECT_WINDOW_RST;
        drop_ms       = DISCONNECT_AFTER_RST;
        foreach (line_head[i])
            line_head[i] = 8'h00;
        drop_line();
        quiet_ms      = '0;
        link_age_ms   = '0;
        link_up       = 1'b0;
        link_count    = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIRECTED[i].mode, DIRECTED[i].rx_byte, DIRECTED[i].typed,
                      DIRECTED[i].rsp);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            case (p)
                1:
                begin
                    write_all(16'd1, 16'd1, 16'd1);
                    write_reg(CFG_UNUSED, 16'($urandom_range(65535)));
                end
                2:       write_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
                5:       write_all(16'($urandom_range(1, 60)), 16'hFFFF, 16'hFFFF);
                6:       write_all(16'hFFFF, 16'($urandom_range(1, 40)), 16'd1);
                3, 4, 7: write_all(16'($urandom_range(1, 60)), 16'($urandom_range(1, 40)),
                                   16'($urandom_range(1, 80)));
                default: ;
            endcase
            cfg_ch.valid <= 1'b0;
            case (IDLE_PLAN[p])
                IDLE_SENDER:   begin src_idle_pct = 63; snk_stall_pct = 0;  end
                IDLE_RECEIVER: begin src_idle_pct = 0;  snk_stall_pct = 63; end
                IDLE_BOTH:     begin src_idle_pct = 8;  snk_stall_pct = 8;  end
                default:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            endcase
            if (p == 2)
            begin
                // pending line survives a long silence with the timeout at its maximum
                send_item(MODE_BYTE, "a");
                send_item(MODE_BYTE, "b");
                send_ticks(200);
                send_item(MODE_BYTE, "c");
                send_item(MODE_BYTE, CHAR_LF);
            end
            begin : random_phase
                int start_beats;
                start_beats = beats_sent;
                while (beats_sent - start_beats < PHASE_BEATS)
                begin
                    send_sequence();
                    if ($urandom_range(99) == 0)
                        drain_results();
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && line_results.size() == 0)
            $display("uart_command_line_recognizer_top: match");
        else
            $display("uart_command_line_recognizer_top: mismatch");
        $finish;
    end

endmodule

// ----- uart_command_line_recognizer_top.f -----
+incdir+rtl/core
rtl/core/ucl_pkg.sv
rtl/core/ucl_if.sv
rtl/core/uart_command_line_recognizer_top.sv
bench/tb_top.sv
